// ===== hw/rtl/bqc_pkg.sv =====
`timescale 1ns / 1ps

package bqc_pkg;

  localparam int PCM_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 4;
  localparam int CFG_DATA_WIDTH  = 32;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_FILTER_ENABLE  = 4'd0,
    REG_LOWPASS_ENABLE = 4'd1,
    REG_HP_GAIN        = 4'd2,
    REG_HP_FB1         = 4'd3,
    REG_HP_FB2         = 4'd4,
    REG_LP_GAIN        = 4'd5,
    REG_LP_FB1         = 4'd6,
    REG_LP_FB2         = 4'd7
  } cfg_reg_t;

  typedef enum logic {
    STAGE_HP = 1'b0,
    STAGE_LP = 1'b1
  } stage_t;

  typedef enum logic [1:0] {
    COEF_GAIN = 2'd0,
    COEF_FB1  = 2'd1,
    COEF_FB2  = 2'd2
  } coef_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_SUB  = 2'd2
  } acc_op_t;

  typedef struct packed {
    logic      load_in;
    stage_t    stage;
    logic      sum_a;
    logic      sum_b;
    logic      mul_en;
    coef_sel_t coef_sel;
    acc_op_t   acc_op;
    logic      commit;
    logic      clamp;
    logic      load_out;
    logic      bypass;
  } bqc_cmd_t;

endpackage

// ===== hw/rtl/bqc_if.sv =====
`timescale 1ns / 1ps

interface bqc_pcm_in_if import bqc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [PCM_WIDTH-1:0] pcm_in;

  modport source (output valid, output pcm_in, input ready);
  modport sink (input valid, input pcm_in, output ready);
endinterface

interface bqc_pcm_out_if import bqc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [PCM_WIDTH-1:0] pcm_out;

  modport source (output valid, output pcm_out, input ready);
  modport sink (input valid, input pcm_out, output ready);
endinterface

interface bqc_cfg_if import bqc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CFG_INDEX_WIDTH-1:0] index;
  logic [CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/biquad_bandpass_cascade.sv =====
`timescale 1ns / 1ps

// Band-pass filter for signed 16-bit PCM: a direct-form-I high-pass biquad
// followed by a low-pass biquad, Q4.28 internal arithmetic with saturating
// sums and Q2.22 coefficients written through the cfg port. One multiplier is
// shared by both stages and steps through three products per stage. A new
// sample is accepted only once the previous one has been loaded into the
// output register; the low-pass stage can be switched off, and with filtering
// disabled the input is passed through. A finished sample waits in the output
// register; the next sample is taken while it waits. Configuration must be
// written only while no sample is in flight.
module biquad_bandpass_cascade import bqc_pkg::*; #(
  parameter int COEF_WIDTH  = 24,
  parameter int STATE_WIDTH = 32
) (
  input logic           clk,
  input logic           rst,
  bqc_pcm_in_if.sink    sample_in,
  bqc_pcm_out_if.source sample_out,
  bqc_cfg_if.sink       cfg
);

  logic                         filter_enable;
  logic                         lowpass_enable;
  logic signed [COEF_WIDTH-1:0] hp_gain, hp_fb1, hp_fb2;
  logic signed [COEF_WIDTH-1:0] lp_gain, lp_fb1, lp_fb2;
  logic signed [COEF_WIDTH-1:0] cfg_coef;
  bqc_cmd_t                     cmd;

  assign cfg.ready = 1'b1;
  assign cfg_coef  = cfg.data[COEF_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable  <= 1'b1;
      lowpass_enable <= 1'b1;
      hp_gain        <= '0;
      hp_fb1         <= '0;
      hp_fb2         <= '0;
      lp_gain        <= '0;
      lp_fb1         <= '0;
      lp_fb2         <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_FILTER_ENABLE:  filter_enable  <= cfg.data[0];
        REG_LOWPASS_ENABLE: lowpass_enable <= cfg.data[0];
        REG_HP_GAIN:        hp_gain        <= cfg_coef;
        REG_HP_FB1:         hp_fb1         <= cfg_coef;
        REG_HP_FB2:         hp_fb2         <= cfg_coef;
        REG_LP_GAIN:        lp_gain        <= cfg_coef;
        REG_LP_FB1:         lp_fb1         <= cfg_coef;
        REG_LP_FB2:         lp_fb2         <= cfg_coef;
        default:            filter_enable  <= filter_enable;
      endcase
    end
  end

  bqc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .filter_enable  (filter_enable),
    .lowpass_enable (lowpass_enable),
    .in_valid       (sample_in.valid),
    .in_ready       (sample_in.ready),
    .out_valid      (sample_out.valid),
    .out_ready      (sample_out.ready),
    .cmd            (cmd)
  );

  bqc_datapath #(
    .COEF_WIDTH  (COEF_WIDTH),
    .STATE_WIDTH (STATE_WIDTH)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .pcm_in  (sample_in.pcm_in),
    .hp_gain (hp_gain),
    .hp_fb1  (hp_fb1),
    .hp_fb2  (hp_fb2),
    .lp_gain (lp_gain),
    .lp_fb1  (lp_fb1),
    .lp_fb2  (lp_fb2),
    .pcm_out (sample_out.pcm_out)
  );

endmodule

// ===== hw/rtl/bqc_ctrl.sv =====
`timescale 1ns / 1ps

module bqc_ctrl import bqc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     filter_enable,
  input  logic     lowpass_enable,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output bqc_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM_A,
    S_SUM_B,
    S_MUL_G,
    S_MUL_F1,
    S_MUL_F2,
    S_FIN,
    S_CLAMP,
    S_OUT
  } state_t;

  state_t state;
  stage_t stage;
  logic   bypass;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.stage    = stage;
    cmd.bypass   = bypass;
    cmd.coef_sel = COEF_GAIN;
    cmd.acc_op   = ACC_HOLD;
    case (state)
      S_IDLE:   cmd.load_in = in_valid;
      S_SUM_A:  cmd.sum_a = 1'b1;
      S_SUM_B:  cmd.sum_b = 1'b1;
      S_MUL_G: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_GAIN;
      end
      S_MUL_F1: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_FB1;
        cmd.acc_op   = ACC_LOAD;
      end
      S_MUL_F2: begin
        cmd.mul_en   = 1'b1;
        cmd.coef_sel = COEF_FB2;
        cmd.acc_op   = ACC_SUB;
      end
      S_FIN: begin
        cmd.acc_op = ACC_SUB;
        cmd.commit = 1'b1;
      end
      S_CLAMP:  cmd.clamp = 1'b1;
      S_OUT:    cmd.load_out = out_free;
      default:  cmd.load_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      stage     <= STAGE_HP;
      bypass    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The output register is loaded only in S_OUT and only when it is free, so a
      // waiting result is never overwritten.
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            bypass <= !filter_enable;
            stage  <= STAGE_HP;
            state  <= filter_enable ? S_SUM_A : S_OUT;
          end
        end
        S_SUM_A:  state <= S_SUM_B;
        S_SUM_B:  state <= S_MUL_G;
        S_MUL_G:  state <= S_MUL_F1;
        S_MUL_F1: state <= S_MUL_F2;
        S_MUL_F2: state <= S_FIN;
        S_FIN: begin
          if (stage == STAGE_HP && lowpass_enable) begin
            stage <= STAGE_LP;
            state <= S_SUM_A;
          end else begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP:  state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bqc_datapath.sv =====
`timescale 1ns / 1ps

module bqc_datapath import bqc_pkg::*; #(
  parameter int COEF_WIDTH  = 24,
  parameter int STATE_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bqc_cmd_t                     cmd,
  input  logic signed [PCM_WIDTH-1:0]  pcm_in,
  input  logic signed [COEF_WIDTH-1:0] hp_gain,
  input  logic signed [COEF_WIDTH-1:0] hp_fb1,
  input  logic signed [COEF_WIDTH-1:0] hp_fb2,
  input  logic signed [COEF_WIDTH-1:0] lp_gain,
  input  logic signed [COEF_WIDTH-1:0] lp_fb1,
  input  logic signed [COEF_WIDTH-1:0] lp_fb2,
  output logic signed [PCM_WIDTH-1:0]  pcm_out
);

  localparam int SW       = STATE_WIDTH;
  localparam int CW       = COEF_WIDTH;
  localparam int FRAC     = SW - 4;
  localparam int PW       = CW + SW;
  localparam int CLAMP_W  = SW - 2;
  localparam int SCALE_W  = CLAMP_W + 15;
  localparam logic signed [SW-1:0] ONE_Q     = {3'b000, 1'b1, {FRAC{1'b0}}};
  localparam logic signed [SW-1:0] NEG_ONE_Q = -ONE_Q;

  // Q1.15 sample placed in the Q4.FRAC word; it never exceeds the range.
  function automatic logic signed [SW-1:0] widen(input logic signed [PCM_WIDTH-1:0] v);
    widen = {{3{v[PCM_WIDTH-1]}}, v, {(SW-19){1'b0}}};
  endfunction

  function automatic logic signed [SW-1:0] sat(input logic signed [SW+1:0] v);
    if (v[SW+1:SW-1] == 3'b000 || v[SW+1:SW-1] == 3'b111) begin
      sat = v[SW-1:0];
    end else if (v[SW+1]) begin
      sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  logic signed [PCM_WIDTH-1:0] sample;
  logic signed [PCM_WIDTH-1:0] hp_in_d1, hp_in_d2;
  logic signed [SW-1:0]        hp_out_d1, hp_out_d2;
  logic signed [SW-1:0]        lp_in_d1, lp_in_d2, lp_out_d1, lp_out_d2;
  logic signed [SW-1:0]        sum, acc, acc_next;
  logic signed [PW-1:0]        prod;
  logic signed [CLAMP_W-1:0]   yc;

  logic signed [SW-1:0]        x_sel, x1_sel, x2_sel, y1_sel, y2_sel;
  logic signed [CW-1:0]        coef;
  logic signed [SW-1:0]        mul_opnd;
  logic signed [SW+1:0]        x_ext, x1_dbl, sum_a_raw, sum_b_raw, acc_sub_raw;
  logic signed [SW+1:0]        scaled_raw;
  logic signed [SW-1:0]        scaled;
  logic signed [SW-1:0]        clamped;
  logic signed [SCALE_W-1:0]   scaled_out, biased_out;
  logic signed [PCM_WIDTH-1:0] filt_out;

  always_comb begin
    if (cmd.stage == STAGE_HP) begin
      x_sel  = widen(sample);
      x1_sel = widen(hp_in_d1);
      x2_sel = widen(hp_in_d2);
      y1_sel = hp_out_d1;
      y2_sel = hp_out_d2;
    end else begin
      // The low-pass input is the high-pass result just committed.
      x_sel  = hp_out_d1;
      x1_sel = lp_in_d1;
      x2_sel = lp_in_d2;
      y1_sel = lp_out_d1;
      y2_sel = lp_out_d2;
    end

    case (cmd.coef_sel)
      COEF_GAIN: begin
        coef     = (cmd.stage == STAGE_HP) ? hp_gain : lp_gain;
        mul_opnd = sum;
      end
      COEF_FB1: begin
        coef     = (cmd.stage == STAGE_HP) ? hp_fb1 : lp_fb1;
        mul_opnd = y1_sel;
      end
      COEF_FB2: begin
        coef     = (cmd.stage == STAGE_HP) ? hp_fb2 : lp_fb2;
        mul_opnd = y2_sel;
      end
      default: begin
        coef     = '0;
        mul_opnd = '0;
      end
    endcase
  end

  assign x_ext     = {{2{x_sel[SW-1]}}, x_sel};
  assign x1_dbl    = {x1_sel[SW-1], x1_sel, 1'b0};
  assign sum_a_raw = (cmd.stage == STAGE_HP) ? x_ext - x1_dbl : x_ext + x1_dbl;
  assign sum_b_raw = {{2{sum[SW-1]}}, sum} + {{2{x2_sel[SW-1]}}, x2_sel};

  // Arithmetic shift of the product by the coefficient fraction bits (floor).
  assign scaled_raw  = prod[PW-1:CW-2];
  assign scaled      = sat(scaled_raw);
  assign acc_sub_raw = {{2{acc[SW-1]}}, acc} - {{2{scaled[SW-1]}}, scaled};

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD: acc_next = scaled;
      ACC_SUB:  acc_next = sat(acc_sub_raw);
      default:  acc_next = acc;
    endcase
  end

  always_comb begin
    if (acc > ONE_Q) begin
      clamped = ONE_Q;
    end else if (acc < NEG_ONE_Q) begin
      clamped = NEG_ONE_Q;
    end else begin
      clamped = acc;
    end
  end

  // y * 32767 as (y << 15) - y, then truncation toward zero.
  assign scaled_out = {yc, 15'b0} - {{15{yc[CLAMP_W-1]}}, yc};
  assign biased_out = scaled_out[SCALE_W-1] ?
                      scaled_out + {{(SCALE_W-FRAC){1'b0}}, {FRAC{1'b1}}} : scaled_out;
  assign filt_out   = biased_out[FRAC+15:FRAC];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample <= pcm_in;
    end
    if (cmd.sum_a) begin
      sum <= sat(sum_a_raw);
    end else if (cmd.sum_b) begin
      sum <= sat(sum_b_raw);
    end
    if (cmd.mul_en) begin
      prod <= PW'(coef) * PW'(mul_opnd);
    end
    acc <= acc_next;
    if (cmd.clamp) begin
      yc <= clamped[CLAMP_W-1:0];
    end
    if (cmd.load_out) begin
      pcm_out <= cmd.bypass ? sample : filt_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hp_in_d1  <= '0;
      hp_in_d2  <= '0;
      hp_out_d1 <= '0;
      hp_out_d2 <= '0;
      lp_in_d1  <= '0;
      lp_in_d2  <= '0;
      lp_out_d1 <= '0;
      lp_out_d2 <= '0;
    end else if (cmd.commit) begin
      if (cmd.stage == STAGE_HP) begin
        hp_in_d2  <= hp_in_d1;
        hp_in_d1  <= sample;
        hp_out_d2 <= hp_out_d1;
        hp_out_d1 <= acc_next;
      end else begin
        lp_in_d2  <= lp_in_d1;
        lp_in_d1  <= hp_out_d1;
        lp_out_d2 <= lp_out_d1;
        lp_out_d1 <= acc_next;
      end
    end
  end

endmodule

// ===== hw/rtl/bqc_checker.sv =====
`timescale 1ns / 1ps

module bqc_checker import bqc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [PCM_WIDTH-1:0] pcm_out
);

  logic       in_acc, out_acc;
  logic [1:0] pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Samples accepted whose results have not yet been delivered.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pcm_out))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("new sample accepted while one is being filtered");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> pending != 2'd0)
    else $error("result delivered with no sample outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two samples outstanding");

endmodule

bind biquad_bandpass_cascade bqc_checker u_bqc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample_in.valid),
  .in_ready  (sample_in.ready),
  .out_valid (sample_out.valid),
  .out_ready (sample_out.ready),
  .pcm_out   (sample_out.pcm_out)
);
